FILE: design/ppce_pkg.sv
// Shared types, constants and scaling factors for the pen plot command encoder.
package ppce_pkg;

	localparam int X_RANGE = 280;
	localparam int Y_RANGE = 192;

	localparam int SCREEN_BITS = 10;

	localparam int X_RECIP_BITS = 28;
	localparam int X_RECIP = (2 ** X_RECIP_BITS + X_RANGE - 1) / X_RANGE;
	localparam int X_PROD_W = 9 + X_RECIP_BITS;
	localparam int X_SHIFT = X_RECIP_BITS - SCREEN_BITS;
	localparam int SX_W = SCREEN_BITS;

	localparam int Y_RECIP_BITS = 26;
	localparam int Y_RECIP = (2 ** Y_RECIP_BITS + Y_RANGE - 1) / Y_RANGE;
	localparam int Y_PROD_W = 8 + Y_RECIP_BITS;
	localparam int Y_SHIFT = Y_RECIP_BITS - SCREEN_BITS;
	localparam int SY_W = SCREEN_BITS + 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] BYTE_START = 8'o035;
	localparam logic [7:0] BYTE_END = 8'o377;
	localparam logic [7:0] BYTE_CLEAR = 8'o030;

	typedef enum logic [1:0] {
		ACT_PLOT = 2'd0,
		ACT_PEN_UP = 2'd1,
		ACT_PEN_DOWN = 2'd2,
		ACT_ERASE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		OP_ERR = 3'd0,
		OP_POINT = 3'd1,
		OP_START_POINT = 3'd2,
		OP_END = 3'd3,
		OP_ERASE_DOWN = 3'd4,
		OP_ERASE_UP = 3'd5
	} op_t;

	typedef struct packed {
		op_t op;
		logic [8:0] x;
		logic [7:0] y;
	} entry_t;

	typedef struct packed {
		logic push;
		entry_t entry;
	} front_req_t;

endpackage

FILE: design/pen_plot_command_encoder.sv
// Top level of the pen plot command encoder: front end, command queue and byte sequencer.
// The block takes one command beat per cycle while its four-entry command queue has room;
// the front end updates the pen state and stored point at once and queues a command entry.
// The sequencer sends one plotter byte per cycle from a registered output stage while the
// output is taken; each command gives its own count of bytes: none for a command without
// output, one for an error or pen up, two or three for erase, four for a plot with the pen
// down and five for pen down, with the next command's bytes following without a gap. The
// scaled coordinates are formed by a reciprocal multiply registered as a command leaves the
// queue, so a command accepted into an empty block passes the queue, the product registers
// and the output register before its first byte appears.
module pen_plot_command_encoder import ppce_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [23:0] s_tdata,   // x_coord[8:0], y_coord[16:9], zero [23:17]
	input logic [1:0] s_tuser,    // action[1:0]
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata,   // out_byte[7:0]
	output logic m_tlast,
	output logic m_tuser          // coord_error[0]
);

	front_req_t req;
	entry_t head;
	logic empty;
	logic full;
	logic pop;
	logic accept;

	assign s_tready = !full;
	assign accept = s_tvalid && s_tready;

	ppce_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.action(s_tuser),
		.x_coord(s_tdata[8:0]),
		.y_coord(s_tdata[16:9]),
		.req(req)
	);

	ppce_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.pop(pop),
		.head(head),
		.empty(empty),
		.full(full)
	);

	ppce_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

endmodule

FILE: design/ppce_front.sv
// Command front end: keeps pen state and last point, classifies each command.
module ppce_front import ppce_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [1:0] action,
	input logic [8:0] x_coord,
	input logic [7:0] y_coord,
	output front_req_t req
);

	localparam logic [8:0] X_LIMIT = 9'(X_RANGE);
	localparam logic [7:0] Y_LIMIT = 8'(Y_RANGE);

	logic pen_q;
	logic [8:0] last_x_q;
	logic [7:0] last_y_q;

	logic pen_d;
	logic [8:0] last_x_d;
	logic [7:0] last_y_d;
	logic push;
	entry_t entry;

	always_comb begin
		push = 1'b0;
		entry.op = OP_ERR;
		entry.x = x_coord;
		entry.y = y_coord;
		pen_d = pen_q;
		last_x_d = last_x_q;
		last_y_d = last_y_q;
		case (action_t'(action))
			ACT_PLOT: begin
				if (x_coord >= X_LIMIT || y_coord >= Y_LIMIT) begin
					push = 1'b1;
					entry.op = OP_ERR;
				end else begin
					last_x_d = x_coord;
					last_y_d = y_coord;
					push = pen_q;
					entry.op = OP_POINT;
				end
			end
			ACT_PEN_UP: begin
				push = pen_q;
				entry.op = OP_END;
				pen_d = 1'b0;
			end
			ACT_PEN_DOWN: begin
				push = !pen_q;
				entry.op = OP_START_POINT;
				entry.x = last_x_q;
				entry.y = last_y_q;
				pen_d = 1'b1;
			end
			default: begin
				push = 1'b1;
				entry.op = pen_q ? OP_ERASE_DOWN : OP_ERASE_UP;
				pen_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q <= 1'b0;
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (accept) begin
			pen_q <= pen_d;
			last_x_q <= last_x_d;
			last_y_q <= last_y_d;
		end
	end

	assign req.push = accept && push;
	assign req.entry = entry;

endmodule

FILE: design/ppce_queue.sv
// Short command queue between the front end and the byte sequencer.
module ppce_queue import ppce_pkg::*; (
	input logic clk,
	input logic arst_n,
	input front_req_t req,
	input logic pop,
	output entry_t head,
	output logic empty,
	output logic full
);

	entry_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (req.push) begin
			mem_q[wr_ptr_q] <= req.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (req.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (req.push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !req.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !req.push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");

endmodule

FILE: design/ppce_back.sv
// Byte sequencer: scales the point and sends each command's bytes one per beat.
module ppce_back import ppce_pkg::*; (
	input logic clk,
	input logic arst_n,
	input entry_t head,
	input logic empty,
	output logic pop,
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata,
	output logic m_tlast,
	output logic m_tuser
);

	localparam logic [X_RECIP_BITS-1:0] X_MULT = X_RECIP_BITS'(X_RECIP);
	localparam logic [Y_RECIP_BITS-1:0] Y_MULT = Y_RECIP_BITS'(Y_RECIP);
	localparam logic [7:0] Y_TOP = 8'(Y_RANGE);

	logic busy_q;
	op_t op_q;
	logic [2:0] idx_q;
	logic [X_PROD_W-1:0] prod_x_q;
	logic [Y_PROD_W-1:0] prod_y_q;

	logic m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic m_tlast_q;
	logic m_tuser_q;

	logic [SX_W-1:0] sx;
	logic [SY_W-1:0] sy;
	logic [2:0] last_idx;
	logic [1:0] pt_idx;
	logic [7:0] pt_byte;
	logic [7:0] beat_byte;
	logic beat_last;
	logic beat_err;
	logic out_free;
	logic emit;
	logic done;

	assign sx = prod_x_q[X_SHIFT +: SX_W];
	assign sy = prod_y_q[Y_SHIFT +: SY_W];

	always_comb begin
		case (op_q)
			OP_POINT: last_idx = 3'd3;
			OP_START_POINT: last_idx = 3'd4;
			OP_ERASE_DOWN: last_idx = 3'd2;
			OP_ERASE_UP: last_idx = 3'd1;
			default: last_idx = 3'd0;
		endcase
	end

	always_comb begin
		pt_idx = (op_q == OP_START_POINT) ? 2'(idx_q - 3'd1) : idx_q[1:0];
		case (pt_idx)
			2'd0: pt_byte = {4'b0, sx[9:6]};
			2'd1: pt_byte = {2'b0, sx[5:0]};
			2'd2: pt_byte = {3'b0, sy[10:6]};
			default: pt_byte = {2'b0, sy[5:0]};
		endcase
	end

	always_comb begin
		beat_err = 1'b0;
		beat_last = (idx_q == last_idx);
		case (op_q)
			OP_ERR: begin
				beat_byte = 8'd0;
				beat_err = 1'b1;
			end
			OP_POINT: beat_byte = pt_byte;
			OP_START_POINT: beat_byte = (idx_q == 3'd0) ? BYTE_START : pt_byte;
			OP_END: beat_byte = BYTE_END;
			OP_ERASE_DOWN: begin
				case (idx_q)
					3'd0: beat_byte = BYTE_END;
					3'd1: beat_byte = BYTE_CLEAR;
					default: beat_byte = BYTE_END;
				endcase
			end
			default: beat_byte = (idx_q == 3'd0) ? BYTE_CLEAR : BYTE_END;
		endcase
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign emit = busy_q && out_free;
	assign done = emit && (idx_q == last_idx);
	assign pop = !empty && (!busy_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 3'd1;
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head.op;
			prod_x_q <= X_PROD_W'(head.x) * X_PROD_W'(X_MULT);
			prod_y_q <= (Y_PROD_W'(Y_TOP) - Y_PROD_W'(head.y)) * Y_PROD_W'(Y_MULT);
		end
		if (emit) begin
			m_tdata_q <= beat_byte;
			m_tlast_q <= beat_last;
			m_tuser_q <= beat_err;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;
	assign m_tuser = m_tuser_q;

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= last_idx)
		else $error("byte index ran past the end of the command");

	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q) |-> (m_tlast_q && m_tdata_q == 8'd0))
		else $error("error beat is not a single zero byte");

	a_pop_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (busy_q && idx_q == 3'd0))
		else $error("popped command did not start a new run");

endmodule
